>>> hw/rtl/atq_pkg.sv
// ----------------------------------------------------------------------------
// atq_pkg
// widths, codes, record types and output packing for the accelerometer tilt
// to quaternion pipeline
// ----------------------------------------------------------------------------
package atq_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int FRACTION_BITS = 14;
  localparam int OUT_BITS      = 16;
  localparam int PRE_SHIFT     = 13;
  localparam int UNIT_BITS     = 30;
  localparam int POLE_RATIO    = 50000;
  localparam int POLE_BITS     = 16;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_OFFSET = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_DIVISOR = 1'b1;

  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(512);
  localparam logic [SAMPLE_BITS-1:0] SCALE_RESET  = SAMPLE_BITS'(200);

  localparam int BOUND_BITS = SAMPLE_BITS + 2;
  localparam int A_BITS     = SAMPLE_BITS + 1;
  localparam int SQ_BITS    = 2 * A_BITS;
  localparam int R2_BITS    = SQ_BITS + 1;
  localparam int N2_BITS    = SQ_BITS + 2;
  localparam int NACC_BITS  = 2 * ((N2_BITS + 2 * PRE_SHIFT + 1) / 2);
  localparam int N_STEPS    = NACC_BITS / 2;
  localparam int N_BITS     = N_STEPS;
  localparam int DR_BITS    = N_BITS + 1;
  localparam int Q_BITS     = UNIT_BITS + 1;
  localparam int D_STEPS    = Q_BITS;
  localparam int H_STEPS    = Q_BITS;
  localparam int HACC_BITS  = 2 * H_STEPS;
  localparam int P_BITS     = 2 * Q_BITS;

  localparam logic [P_BITS-1:0] POS_LIMIT = P_BITS'(2 ** (OUT_BITS - 1) - 1);
  localparam logic [P_BITS-1:0] NEG_LIMIT = POS_LIMIT + P_BITS'(1);
  localparam logic [P_BITS-1:0] W_HALF = P_BITS'(1) << (UNIT_BITS - 1 - FRACTION_BITS);
  localparam logic [P_BITS-1:0] P_HALF = P_BITS'(1) << (2 * UNIT_BITS - 1 - FRACTION_BITS);

  typedef struct packed {
    logic zero;
    logic pole;
    logic zneg;
    logic neg_x;
    logic neg_y;
  } flags_t;

  typedef struct packed {
    logic [A_BITS-1:0] mag;
    logic              neg;
    logic              pos;
  } axis_t;

  typedef struct packed {
    flags_t            f;
    logic [A_BITS-1:0] ax;
    logic [A_BITS-1:0] ay;
    logic [A_BITS-1:0] az;
  } s1_t;

  typedef struct packed {
    flags_t             f;
    logic [A_BITS-1:0]  ax;
    logic [A_BITS-1:0]  ay;
    logic [A_BITS-1:0]  az;
    logic [R2_BITS-1:0] r2;
    logic [N2_BITS-1:0] n2;
  } s2_t;

  typedef struct packed {
    logic [N_BITS-1:0] root;
    logic [N_BITS:0]   rem;
  } root1_t;

  typedef struct packed {
    flags_t               f;
    logic [A_BITS-1:0]    ax;
    logic [A_BITS-1:0]    ay;
    logic [A_BITS-1:0]    az;
    logic [NACC_BITS-1:0] acc_n;
    logic [NACC_BITS-1:0] acc_l;
    root1_t               n;
    root1_t               l;
  } sq1_t;

  typedef struct packed {
    logic [DR_BITS-1:0] rem;
    logic [Q_BITS-1:0]  q;
  } divq_t;

  typedef struct packed {
    flags_t             f;
    logic [DR_BITS-1:0] dn;
    logic [DR_BITS-1:0] dl;
    logic               feed_w;
    logic               feed_s;
    divq_t              w;
    divq_t              s;
    divq_t              x;
    divq_t              y;
  } dv_t;

  typedef struct packed {
    logic [Q_BITS-1:0] root;
    logic [Q_BITS:0]   rem;
  } root2_t;

  typedef struct packed {
    flags_t               f;
    logic [Q_BITS-1:0]    fx;
    logic [Q_BITS-1:0]    fy;
    logic [HACC_BITS-1:0] acc_w;
    logic [HACC_BITS-1:0] acc_s;
    root2_t               w;
    root2_t               s;
  } sq2_t;

  typedef struct packed {
    flags_t            f;
    logic [Q_BITS-1:0] wh;
    logic [P_BITS-1:0] px;
    logic [P_BITS-1:0] py;
  } mu_t;

  // saturate a magnitude with its sign into the output format
  function automatic logic signed [OUT_BITS-1:0] pack_out(input logic [P_BITS-1:0] mag,
                                                          input logic neg);
    logic [OUT_BITS-1:0] m;
    m = mag[OUT_BITS-1:0];
    if (neg) begin
      if (mag > NEG_LIMIT) return {1'b1, {(OUT_BITS-1){1'b0}}};
      return signed'(-m);
    end
    if (mag > POS_LIMIT) return {1'b0, {(OUT_BITS-1){1'b1}}};
    return signed'(m);
  endfunction

  // elaboration only
  function automatic logic [63:0] isqrt_const(input logic [63:0] a);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = a;
    root = 64'd0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  localparam logic signed [OUT_BITS-1:0] ZERO_W = pack_out(
    P_BITS'((isqrt_const(64'd1 << (2 * UNIT_BITS - 1)) +
             (64'd1 << (UNIT_BITS - 1 - FRACTION_BITS))) >> (UNIT_BITS - FRACTION_BITS)),
    1'b0);
  localparam logic signed [OUT_BITS-1:0] ONE_Q = pack_out(P_BITS'(1) << FRACTION_BITS, 1'b0);

endpackage

>>> hw/rtl/accel_tilt_quaternion_core.sv
// ----------------------------------------------------------------------------
// accel_tilt_quaternion_core
// raw three-axis accelerometer sample in, tilt quaternion toward (0,0,-1) out
// ----------------------------------------------------------------------------
// Usage
//   config: cfg_wr_en/cfg_index/cfg_data write center_offset (index 0) and
//     scale_divisor (index 1); write only while no item is in flight.
//   input: accel_x/y/z are taken at an edge where in_valid is high and
//     in_stall is low.
//   output: quat_w/x/y/z hold one result while out_valid is high; it is
//     taken at an edge where out_stall is low. quat_z is always zero.
//   timing: 93 register stages; one item per cycle while out_stall does not
//     hold a valid result. The depth comes from a bank of two square roots,
//     a bank of four divisions and a second bank of two square roots, one
//     bit per stage each.
//   stall: a stalled result freezes the whole pipeline and raises in_stall
//     in the same cycle; nothing is dropped or repeated.
//   reset: rst clears all valid bits and loads center_offset 512 and
//     scale_divisor 200.
// ----------------------------------------------------------------------------
module accel_tilt_quaternion_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [atq_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [atq_pkg::SAMPLE_BITS-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [atq_pkg::SAMPLE_BITS-1:0]        accel_x,
  input  logic [atq_pkg::SAMPLE_BITS-1:0]        accel_y,
  input  logic [atq_pkg::SAMPLE_BITS-1:0]        accel_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [atq_pkg::OUT_BITS-1:0]    quat_w,
  output logic signed [atq_pkg::OUT_BITS-1:0]    quat_x,
  output logic signed [atq_pkg::OUT_BITS-1:0]    quat_y,
  output logic signed [atq_pkg::OUT_BITS-1:0]    quat_z
);

  localparam int SB     = atq_pkg::SAMPLE_BITS;
  localparam int BB     = atq_pkg::BOUND_BITS;
  localparam int AB     = atq_pkg::A_BITS;
  localparam int R2B    = atq_pkg::R2_BITS;
  localparam int N2B    = atq_pkg::N2_BITS;
  localparam int NACC   = atq_pkg::NACC_BITS;
  localparam int NB     = atq_pkg::N_BITS;
  localparam int DRB    = atq_pkg::DR_BITS;
  localparam int QB     = atq_pkg::Q_BITS;
  localparam int HACC   = atq_pkg::HACC_BITS;
  localparam int PB     = atq_pkg::P_BITS;
  localparam int PRE    = atq_pkg::PRE_SHIFT;
  localparam int UNIT   = atq_pkg::UNIT_BITS;
  localparam int FB     = atq_pkg::FRACTION_BITS;
  localparam int PW     = R2B + atq_pkg::POLE_BITS;
  localparam int NS     = atq_pkg::N_STEPS;
  localparam int DS     = atq_pkg::D_STEPS;
  localparam int HS     = atq_pkg::H_STEPS;
  localparam int STAGES = NS + DS + HS + 6;

  function automatic atq_pkg::axis_t clamp_axis(input logic [SB-1:0] raw,
                                               input logic [SB-1:0] off,
                                               input logic [BB-1:0] bound);
    logic signed [BB:0] v;
    logic signed [BB:0] b;
    logic signed [BB:0] m;
    atq_pkg::axis_t r;
    v = signed'(({3'b000, raw} - {3'b000, off}) << 1);
    b = signed'({1'b0, bound});
    if (v > b) v = b;
    else if (v < -b) v = -b;
    m = v[BB] ? -v : v;
    r.mag = m[AB-1:0];
    r.neg = v[BB];
    r.pos = !v[BB] && (v != '0);
    return r;
  endfunction

  function automatic atq_pkg::root1_t root1_step(input atq_pkg::root1_t s,
                                                input logic [1:0] pair);
    logic [NB+2:0] t;
    logic [NB+2:0] trial;
    logic [NB+2:0] diff;
    atq_pkg::root1_t r;
    t     = {s.rem, pair};
    trial = {1'b0, s.root, 2'b01};
    diff  = t - trial;
    if (t >= trial) begin
      r.rem  = diff[NB:0];
      r.root = {s.root[NB-2:0], 1'b1};
    end else begin
      r.rem  = t[NB:0];
      r.root = {s.root[NB-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic atq_pkg::root2_t root2_step(input atq_pkg::root2_t s,
                                                input logic [1:0] pair);
    logic [QB+2:0] t;
    logic [QB+2:0] trial;
    logic [QB+2:0] diff;
    atq_pkg::root2_t r;
    t     = {s.rem, pair};
    trial = {1'b0, s.root, 2'b01};
    diff  = t - trial;
    if (t >= trial) begin
      r.rem  = diff[QB:0];
      r.root = {s.root[QB-2:0], 1'b1};
    end else begin
      r.rem  = t[QB:0];
      r.root = {s.root[QB-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic atq_pkg::divq_t div_step(input atq_pkg::divq_t s, input logic b,
                                             input logic [DRB-1:0] d);
    logic [DRB:0] t;
    logic [DRB:0] dx;
    logic [DRB:0] diff;
    atq_pkg::divq_t r;
    t    = {s.rem, b};
    dx   = {1'b0, d};
    diff = t - dx;
    if (t >= dx) begin
      r.rem = diff[DRB-1:0];
      r.q   = {s.q[QB-2:0], 1'b1};
    end else begin
      r.rem = t[DRB-1:0];
      r.q   = {s.q[QB-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [SB-1:0]        center_offset;
  logic [SB-1:0]        scale_divisor;
  logic                 en;
  logic [STAGES-1:0]    vld;
  atq_pkg::s1_t         s1;
  atq_pkg::s2_t         s2;
  atq_pkg::sq1_t        sq1 [0:NS];
  atq_pkg::dv_t         dv [0:DS];
  atq_pkg::sq2_t        sq2_in;
  atq_pkg::sq2_t        sq2 [1:HS];
  atq_pkg::mu_t         mu;
  atq_pkg::axis_t       cx;
  atq_pkg::axis_t       cy;
  atq_pkg::axis_t       cz;
  logic [BB-1:0]        bound;
  logic [PW-1:0]        pole_prod;
  logic [NB-1:0]        zs;
  logic [DRB-1:0]       nm;
  logic [DRB-1:0]       np;
  logic [PB-1:0]        px_next;
  logic [PB-1:0]        py_next;
  logic [PB-1:0]        w_mag;
  logic [PB-1:0]        x_mag;
  logic [PB-1:0]        y_mag;
  logic signed [atq_pkg::OUT_BITS-1:0] w_next;
  logic signed [atq_pkg::OUT_BITS-1:0] x_next;
  logic signed [atq_pkg::OUT_BITS-1:0] y_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      center_offset <= atq_pkg::CENTER_RESET;
      scale_divisor <= atq_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        atq_pkg::CFG_CENTER_OFFSET: center_offset <= cfg_data;
        atq_pkg::CFG_SCALE_DIVISOR: scale_divisor <= cfg_data;
      endcase
    end
  end

  // pipeline advance
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[STAGES-1];
  assign quat_z    = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // stage 1: offset, scale clamp
  always_comb begin
    bound = BB'({2'b00, scale_divisor}) + BB'({1'b0, scale_divisor, 1'b0});
    cx    = clamp_axis(accel_x, center_offset, bound);
    cy    = clamp_axis(accel_y, center_offset, bound);
    cz    = clamp_axis(accel_z, center_offset, bound);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.ax      <= cx.mag;
      s1.ay      <= cy.mag;
      s1.az      <= cz.mag;
      s1.f.zero  <= 1'b0;
      s1.f.pole  <= 1'b0;
      s1.f.zneg  <= cz.neg;
      s1.f.neg_x <= cy.pos;
      s1.f.neg_y <= cx.neg;
    end
  end

  // stage 2: squared lengths
  always_ff @(posedge clk) begin
    if (en) begin
      s2.f  <= s1.f;
      s2.ax <= s1.ax;
      s2.ay <= s1.ay;
      s2.az <= s1.az;
      s2.r2 <= R2B'(s1.ax * s1.ax) + R2B'(s1.ay * s1.ay);
      s2.n2 <= N2B'(s1.ax * s1.ax) + N2B'(s1.ay * s1.ay) + N2B'(s1.az * s1.az);
    end
  end

  // stage 3: classify, load root units
  assign pole_prod = PW'(s2.r2) * PW'(atq_pkg::POLE_RATIO);

  always_ff @(posedge clk) begin
    if (en) begin
      sq1[0].f.zero   <= (s2.n2 == '0);
      sq1[0].f.pole   <= (pole_prod < PW'(s2.n2));
      sq1[0].f.zneg   <= s2.f.zneg;
      sq1[0].f.neg_x  <= s2.f.neg_x;
      sq1[0].f.neg_y  <= s2.f.neg_y;
      sq1[0].ax       <= s2.ax;
      sq1[0].ay       <= s2.ay;
      sq1[0].az       <= s2.az;
      sq1[0].acc_n    <= NACC'(s2.n2) << (2 * PRE);
      sq1[0].acc_l    <= NACC'(s2.r2) << (2 * PRE);
      sq1[0].n        <= '0;
      sq1[0].l        <= '0;
    end
  end

  // vector length and planar length, one root bit per stage
  for (genvar k = 1; k <= NS; k++) begin : g_sq1
    always_ff @(posedge clk) begin
      if (en) begin
        sq1[k].f     <= sq1[k-1].f;
        sq1[k].ax    <= sq1[k-1].ax;
        sq1[k].ay    <= sq1[k-1].ay;
        sq1[k].az    <= sq1[k-1].az;
        sq1[k].n     <= root1_step(sq1[k-1].n, sq1[k-1].acc_n[NACC-1 -: 2]);
        sq1[k].l     <= root1_step(sq1[k-1].l, sq1[k-1].acc_l[NACC-1 -: 2]);
        sq1[k].acc_n <= sq1[k-1].acc_n << 2;
        sq1[k].acc_l <= sq1[k-1].acc_l << 2;
      end
    end
  end

  // divider setup
  always_comb begin
    zs = NB'({sq1[NS].az, {PRE{1'b0}}});
    if (sq1[NS].f.zneg) begin
      nm = {1'b0, sq1[NS].n.root} + {1'b0, zs};
      np = {1'b0, sq1[NS].n.root} - {1'b0, zs};
    end else begin
      nm = {1'b0, sq1[NS].n.root} - {1'b0, zs};
      np = {1'b0, sq1[NS].n.root} + {1'b0, zs};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].f      <= sq1[NS].f;
      dv[0].dn     <= {sq1[NS].n.root, 1'b0};
      dv[0].dl     <= {1'b0, sq1[NS].l.root};
      dv[0].feed_w <= nm[0];
      dv[0].feed_s <= np[0];
      dv[0].w.rem  <= {1'b0, nm[DRB-1:1]};
      dv[0].s.rem  <= {1'b0, np[DRB-1:1]};
      dv[0].x.rem  <= DRB'(sq1[NS].ay) << (PRE - 1);
      dv[0].y.rem  <= DRB'(sq1[NS].ax) << (PRE - 1);
      dv[0].w.q    <= '0;
      dv[0].s.q    <= '0;
      dv[0].x.q    <= '0;
      dv[0].y.q    <= '0;
    end
  end

  // half-angle ratios and axis direction, one quotient bit per stage
  for (genvar k = 1; k <= DS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k].f      <= dv[k-1].f;
        dv[k].dn     <= dv[k-1].dn;
        dv[k].dl     <= dv[k-1].dl;
        dv[k].feed_w <= 1'b0;
        dv[k].feed_s <= 1'b0;
        dv[k].w      <= div_step(dv[k-1].w, dv[k-1].feed_w, dv[k-1].dn);
        dv[k].s      <= div_step(dv[k-1].s, dv[k-1].feed_s, dv[k-1].dn);
        dv[k].x      <= div_step(dv[k-1].x, 1'b0, dv[k-1].dl);
        dv[k].y      <= div_step(dv[k-1].y, 1'b0, dv[k-1].dl);
      end
    end
  end

  always_comb begin
    sq2_in.f     = dv[DS].f;
    sq2_in.fx    = dv[DS].x.q;
    sq2_in.fy    = dv[DS].y.q;
    sq2_in.acc_w = HACC'(dv[DS].w.q) << UNIT;
    sq2_in.acc_s = HACC'(dv[DS].s.q) << UNIT;
    sq2_in.w     = '0;
    sq2_in.s     = '0;
  end

  // half-angle cosine and sine, one root bit per stage
  for (genvar k = 1; k <= HS; k++) begin : g_sq2
    atq_pkg::sq2_t src;
    if (k == 1) begin : g_first
      assign src = sq2_in;
    end else begin : g_next
      assign src = sq2[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq2[k].f     <= src.f;
        sq2[k].fx    <= src.fx;
        sq2[k].fy    <= src.fy;
        sq2[k].w     <= root2_step(src.w, src.acc_w[HACC-1 -: 2]);
        sq2[k].s     <= root2_step(src.s, src.acc_s[HACC-1 -: 2]);
        sq2[k].acc_w <= src.acc_w << 2;
        sq2[k].acc_s <= src.acc_s << 2;
      end
    end
  end

  // axis times sine
  always_comb begin
    px_next = PB'(sq2[HS].fx) * PB'(sq2[HS].s.root);
    py_next = PB'(sq2[HS].fy) * PB'(sq2[HS].s.root);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu.f  <= sq2[HS].f;
      mu.wh <= sq2[HS].w.root;
      mu.px <= px_next;
      mu.py <= py_next;
    end
  end

  // rounding, special cases, output register
  always_comb begin
    w_mag = (PB'(mu.wh) + atq_pkg::W_HALF) >> (UNIT - FB);
    x_mag = (mu.px + atq_pkg::P_HALF) >> (2 * UNIT - FB);
    y_mag = (mu.py + atq_pkg::P_HALF) >> (2 * UNIT - FB);
    priority if (mu.f.zero) begin
      w_next = atq_pkg::ZERO_W;
      x_next = '0;
      y_next = '0;
    end else if (mu.f.pole && mu.f.zneg) begin
      w_next = atq_pkg::ONE_Q;
      x_next = '0;
      y_next = '0;
    end else if (mu.f.pole) begin
      w_next = '0;
      x_next = atq_pkg::ONE_Q;
      y_next = '0;
    end else begin
      w_next = atq_pkg::pack_out(w_mag, 1'b0);
      x_next = atq_pkg::pack_out(x_mag, mu.f.neg_x);
      y_next = atq_pkg::pack_out(y_mag, mu.f.neg_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_w <= w_next;
      quat_x <= x_next;
      quat_y <= y_next;
    end
  end

  a_frozen: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("pipeline moved while stalled");

  a_w_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !quat_w[atq_pkg::OUT_BITS-1])
    else $error("negative w component");

  a_len_root: assert property (@(posedge clk) disable iff (rst)
    vld[NS+2] |-> (sq1[NS].n.root >= NB'({sq1[NS].az, {PRE{1'b0}}})))
    else $error("vector length below its z part");

endmodule

>>> tb/sv/tb_accel_tilt_quaternion_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_quaternion_core
// Drives raw accelerometer samples through the tilt quaternion core under
// several offset and scale settings, predicts every quaternion with an
// integer model of the same math and compares each result field by field.
// The input side gets random gaps and the output side random stalls.
// ----------------------------------------------------------------------------
module tb_accel_tilt_quaternion_core;

  localparam int LIMIT_CYCLES = 5000;
  localparam int SETTLE_CYCLES = 120;

  typedef logic [atq_pkg::SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    logic signed [atq_pkg::OUT_BITS-1:0] w;
    logic signed [atq_pkg::OUT_BITS-1:0] x;
    logic signed [atq_pkg::OUT_BITS-1:0] y;
    logic signed [atq_pkg::OUT_BITS-1:0] z;
  } quat_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [atq_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [atq_pkg::SAMPLE_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  sample_t accel_x, accel_y, accel_z;
  logic out_valid;
  logic out_stall;
  logic signed [atq_pkg::OUT_BITS-1:0] quat_w, quat_x, quat_y, quat_z;

  quat_t expected_quats[$];
  sample_t center_now;
  sample_t scale_now;
  int mismatches;
  int samples_sent;
  int quats_checked;
  int idle_cycles;
  int stall_left;
  bit quiet;

  accel_tilt_quaternion_core DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned a);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint signed scaled_axis(input sample_t raw);
    longint signed bound;
    longint signed v;
    bound = 3 * longint'(scale_now);
    v = 2 * (longint'(raw) - longint'(center_now));
    if (v > bound) v = bound;
    if (v < -bound) v = -bound;
    return v;
  endfunction

  function automatic quat_t predict_tilt(input sample_t rx, input sample_t ry,
                                         input sample_t rz);
    longint signed vx, vy, vz, qw, qx, qy;
    longint unsigned ax, ay, az, r2, n2, n, zs, nm, np, rw, rs, sh, l, fx, fy;
    quat_t q;
    vx = scaled_axis(rx);
    vy = scaled_axis(ry);
    vz = scaled_axis(rz);
    ax = vx < 0 ? -vx : vx;
    ay = vy < 0 ? -vy : vy;
    az = vz < 0 ? -vz : vz;
    r2 = ax * ax + ay * ay;
    n2 = r2 + az * az;
    qw = 0;
    qx = 0;
    qy = 0;
    if (n2 == 0) begin
      qw = (int_sqrt(64'd1 << 59) + (64'd1 << 15)) >> 16;
    end else if (r2 * 50000 < n2) begin
      if (vz < 0) qw = 16384;
      else qx = 16384;
    end else begin
      n = int_sqrt(n2 << 26);
      zs = az << 13;
      nm = (vz < 0) ? n + zs : n - zs;
      np = (vz < 0) ? n - zs : n + zs;
      rw = (nm << 30) / (2 * n);
      rs = (np << 30) / (2 * n);
      sh = int_sqrt(rs << 30);
      l = int_sqrt(r2 << 26);
      fx = 0;
      fy = 0;
      if (l != 0) begin
        fx = (ay << 43) / l;
        fy = (ax << 43) / l;
      end
      qw = (int_sqrt(rw << 30) + (64'd1 << 15)) >> 16;
      qx = (fx * sh + (64'd1 << 45)) >> 46;
      qy = (fy * sh + (64'd1 << 45)) >> 46;
      if (vy > 0) qx = -qx;
      if (vx < 0) qy = -qy;
    end
    q.w = qw[atq_pkg::OUT_BITS-1:0];
    q.x = qx[atq_pkg::OUT_BITS-1:0];
    q.y = qy[atq_pkg::OUT_BITS-1:0];
    q.z = '0;
    return q;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic sample_t rand_sample();
    return sample_t'($urandom_range(0, 1023));
  endfunction

  task automatic send_sample(input sample_t rx, input sample_t ry, input sample_t rz);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    accel_x = rx;
    accel_y = ry;
    accel_z = rz;
    do @(posedge clk); while (in_stall);
    expected_quats.push_back(predict_tilt(rx, ry, rz));
    samples_sent++;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_quats();
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_quats.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [atq_pkg::CFG_IDX_BITS-1:0] idx, input sample_t val);
    drain_quats();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == atq_pkg::CFG_CENTER_OFFSET) center_now = val;
    else scale_now = val;
  endtask

  task automatic test_reset_directed();
    send_sample(512, 512, 512);
    send_sample(512, 512, 0);
    send_sample(512, 512, 1023);
    send_sample(513, 512, 0);
    send_sample(514, 512, 0);
    send_sample(512, 514, 1023);
    send_sample(0, 0, 0);
    send_sample(1023, 1023, 1023);
    send_sample(0, 1023, 512);
    send_sample(1023, 0, 512);
    send_sample(800, 300, 512);
    send_sample(300, 800, 200);
    send_sample(712, 512, 512);
    send_sample(512, 312, 512);
    send_sample(10'h155, 10'h2aa, 10'h155);
    send_sample(10'h2aa, 10'h155, 10'h2aa);
  endtask

  task automatic test_register_extremes();
    write_reg(atq_pkg::CFG_SCALE_DIVISOR, 0);
    send_sample(0, 1023, 700);
    send_sample(1023, 1023, 1023);
    write_reg(atq_pkg::CFG_CENTER_OFFSET, 0);
    write_reg(atq_pkg::CFG_SCALE_DIVISOR, 1);
    send_sample(0, 0, 0);
    send_sample(1, 0, 0);
    send_sample(1023, 1023, 1023);
    send_sample(0, 0, 1);
    write_reg(atq_pkg::CFG_CENTER_OFFSET, 1023);
    write_reg(atq_pkg::CFG_SCALE_DIVISOR, 1023);
    send_sample(1023, 1023, 1023);
    send_sample(0, 0, 0);
    send_sample(1023, 1023, 0);
    send_sample(0, 1023, 1022);
  endtask

  task automatic test_random_sweep(input sample_t center, input sample_t scale, input int count);
    int span, lo, hi;
    sample_t s[3];
    write_reg(atq_pkg::CFG_CENTER_OFFSET, center);
    write_reg(atq_pkg::CFG_SCALE_DIVISOR, scale);
    span = (3 * scale) / 2 + 2;
    lo = int'(center) - span < 0 ? 0 : int'(center) - span;
    hi = int'(center) + span > 1023 ? 1023 : int'(center) + span;
    for (int i = 0; i < count; i++) begin
      quiet = (i / 64) % 4 == 3;
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 9))
          0, 1:    s[k] = rand_sample();
          2:       s[k] = sample_t'(int'(center) + int'($urandom_range(0, 2)) - 1);
          default: s[k] = sample_t'($urandom_range(lo, hi));
        endcase
      end
      send_sample(s[0], s[1], s[2]);
    end
    quiet = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) begin
      send_sample(rand_sample(), rand_sample(), rand_sample());
    end
    drain_quats();
    for (int i = 0; i < 20; i++) begin
      send_sample(rand_sample(), rand_sample(), rand_sample());
    end
  endtask

  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    quat_t e;
    if (!rst && out_valid && !out_stall) begin
      quats_checked++;
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion w=%0d x=%0d", quat_w, quat_x);
      end else begin
        e = expected_quats.pop_front();
        if (quat_w !== e.w || quat_x !== e.x || quat_y !== e.y || quat_z !== e.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     e.w, e.x, e.y, e.z, quat_w, quat_x, quat_y, quat_z);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT_CYCLES) begin
      $display("timeout, %0d quaternions outstanding", expected_quats.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    accel_x = '0;
    accel_y = '0;
    accel_z = '0;
    out_stall = 1'b0;
    stall_left = 0;
    quiet = 1'b0;
    mismatches = 0;
    samples_sent = 0;
    quats_checked = 0;
    idle_cycles = 0;
    center_now = atq_pkg::CENTER_RESET;
    scale_now = atq_pkg::SCALE_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_directed();
    test_register_extremes();
    test_random_sweep(512, 200, 400);
    test_random_sweep(300, 60, 300);
    test_random_sweep(700, 1023, 250);
    test_random_sweep(1023, 1, 200);
    test_random_sweep(0, 400, 250);
    test_drain_pause();
    test_random_sweep(512, 150, 200);
    drain_quats();

    $display("sent %0d samples over several offset/scale settings incl. extremes,",
             samples_sent);
    $display("checked %0d quaternions, %0d mismatches", quats_checked, mismatches);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/atq_pkg.sv
hw/rtl/accel_tilt_quaternion_core.sv
tb/sv/tb_accel_tilt_quaternion_core.sv
